### rtl/core/egcm_pkg.sv
package egcm_pkg;

   // Field widths of the item and result formats
   localparam int COORD_BITS      = 16;
   localparam int SIZE_BITS       = 12;
   localparam int VALUE_BITS      = 32;

   // Table depth default and front-to-back queue depth
   localparam int ENTRIES_DEFAULT = 16;
   localparam int QUEUE_DEPTH     = 2;

   typedef enum logic [1:0] {
      OP_SET = 2'd0,
      OP_GET = 2'd1,
      OP_L2P = 2'd2,
      OP_P2L = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_ZERO = 2'd2
   } status_type;

   // Work kinds handed from front to back
   typedef enum logic [2:0] {
      CMD_REJECT = 3'd0,
      CMD_SET    = 3'd1,
      CMD_GET    = 3'd2,
      CMD_L2P    = 3'd3,
      CMD_P2L_UP = 3'd4,
      CMD_P2L_DN = 3'd5
   } cmd_kind_type;

   typedef struct packed {
      op_type                       op;
      logic signed [COORD_BITS-1:0] coord;
      logic [SIZE_BITS-1:0]         cell_size;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      status_type                   status;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type                 kind;
      logic signed [COORD_BITS-1:0] coord;
      logic [SIZE_BITS-1:0]         size;
   } cmd_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] loc;
      logic [SIZE_BITS-1:0]         size;
   } tbl_entry_type;

endpackage

### rtl/core/egcm_front.sv
module egcm_front import egcm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   logic    hold_vld_ff, hold_vld_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   logic    accept;

   function automatic cmd_type classify(input req_type r);
      cmd_type c;
      c.coord = r.coord;
      c.size  = r.cell_size;
      unique case (r.op)
         OP_SET:  c.kind = (r.cell_size == '0) ? CMD_REJECT : CMD_SET;
         OP_GET:  c.kind = CMD_GET;
         OP_L2P:  c.kind = CMD_L2P;
         OP_P2L:  c.kind = r.coord[COORD_BITS-1] ? CMD_P2L_DN : CMD_P2L_UP;
         default: c.kind = CMD_GET;
      endcase
      return c;
   endfunction

   // Holding register frees as soon as the queue takes the item
   assign busy   = hold_vld_ff && q_full;
   assign accept = start && !busy;
   assign q_push = hold_vld_ff && !q_full;
   assign q_cmd  = hold_cmd_ff;

   always_comb begin
      hold_vld_in = accept || (hold_vld_ff && q_full);
      hold_cmd_in = accept ? classify(req_item) : hold_cmd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

### rtl/core/egcm_queue.sv
module egcm_queue import egcm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type pop_cmd
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   fill_ff, fill_in;
   logic                  do_push, do_pop;

   assign full    = (fill_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/core/egcm_back.sv
module egcm_back import egcm_pkg::*; #(
   parameter int ENTRIES  = ENTRIES_DEFAULT,
   parameter int CNT_BITS = $clog2(ENTRIES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  cmd_type             q_cmd,
   output logic                q_pop,
   output logic                rsp_strobe,
   output rsp_type             rsp_item,
   output logic [CNT_BITS-1:0] tbl_count
);

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic [3:0] {
      BK_IDLE  = 4'b0001,
      BK_SCAN  = 4'b0010,
      BK_SHIFT = 4'b0100,
      BK_WRITE = 4'b1000
   } back_state_type;

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic [CNT_BITS-1:0] left_ff, left_in;
   logic [CNT_BITS-1:0] pend_idx_ff, pend_idx_in;
   logic [CNT_BITS-1:0] pos_ff, pos_in;
   logic                pend_ff, pend_in;
   logic                walk_dn_ff, walk_dn_in;
   logic signed [VALUE_BITS-1:0] total_ff, total_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_type             rsp_ff, rsp_in;

   tbl_entry_type       tbl_mem [ENTRIES];
   tbl_entry_type       rd_data_ff;
   logic [IDX_BITS-1:0] rd_addr, wr_addr;
   tbl_entry_type       wr_data;
   logic                wr_en;

   logic signed [VALUE_BITS-1:0] loc_x, sm1_x, coord_x, sum_tl;
   logic signed [VALUE_BITS-1:0] total_nx, stop_val, end_val;
   logic                loc_neg, stop, hit_match, walk_end, size_one;
   logic [CNT_BITS-1:0] sp, dst_idx;

   assign loc_neg  = rd_data_ff.loc[COORD_BITS-1];
   assign loc_x    = {{(VALUE_BITS-COORD_BITS){loc_neg}}, rd_data_ff.loc};
   assign sm1_x    = {{(VALUE_BITS-SIZE_BITS){1'b0}}, rd_data_ff.size - 1'b1};
   assign coord_x  = {{(VALUE_BITS-COORD_BITS){cmd_ff.coord[COORD_BITS-1]}}, cmd_ff.coord};
   assign sum_tl   = total_ff + loc_x;
   assign walk_end = !pend_ff && (left_ff == '0);
   assign size_one = (cmd_ff.size == SIZE_BITS'(1));
   assign rd_addr  = idx_ff[IDX_BITS-1:0];
   assign dst_idx  = walk_dn_ff ? pend_idx_ff + 1'b1 : pend_idx_ff - 1'b1;

   // Per-entry evaluation of the word returned by the table
   always_comb begin
      total_nx  = total_ff;
      stop      = 1'b0;
      stop_val  = '0;
      hit_match = 1'b0;
      if (pend_ff) begin
         unique case (cmd_ff.kind)
            CMD_GET: begin
               if (rd_data_ff.loc == cmd_ff.coord) begin
                  stop     = 1'b1;
                  stop_val = {{(VALUE_BITS-SIZE_BITS){1'b0}}, rd_data_ff.size};
               end
            end
            CMD_L2P: begin
               if (!loc_neg && loc_x < coord_x) begin
                  total_nx = total_ff + sm1_x;
               end else if (loc_neg && loc_x >= coord_x) begin
                  total_nx = total_ff - sm1_x;
               end
            end
            CMD_P2L_UP: begin
               if (!loc_neg) begin
                  if (sum_tl > coord_x) begin
                     stop     = 1'b1;
                     stop_val = coord_x - total_ff;
                  end else if (sum_tl + sm1_x >= coord_x) begin
                     stop     = 1'b1;
                     stop_val = loc_x;
                  end else begin
                     total_nx = total_ff + sm1_x;
                  end
               end
            end
            CMD_P2L_DN: begin
               if (loc_neg) begin
                  if (sum_tl < coord_x) begin
                     stop     = 1'b1;
                     stop_val = coord_x - total_ff;
                  end else if (sum_tl - sm1_x <= coord_x) begin
                     stop     = 1'b1;
                     stop_val = loc_x;
                  end else begin
                     total_nx = total_ff - sm1_x;
                  end
               end
            end
            CMD_SET: begin
               // first entry at or above the location is the insert point
               if (loc_x >= coord_x) begin
                  stop      = 1'b1;
                  hit_match = (rd_data_ff.loc == cmd_ff.coord);
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cmd_ff.kind) inside
         CMD_GET:                end_val = VALUE_BITS'(1);
         CMD_L2P:                end_val = coord_x + total_ff;
         CMD_P2L_UP, CMD_P2L_DN: end_val = coord_x - total_ff;
         default:                end_val = '0;
      endcase
   end

   assign sp = stop ? pend_idx_ff : count_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      pos_in        = pos_ff;
      walk_dn_in    = walk_dn_ff;
      total_in      = total_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = pos_ff[IDX_BITS-1:0];
      wr_data       = '{loc: cmd_ff.coord, size: cmd_ff.size};

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               total_in = '0;
               pend_in  = 1'b0;
               left_in  = count_ff;
               if (q_cmd.kind == CMD_REJECT) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '{value: '0, status: ST_ZERO};
               end else begin
                  state_in = BK_SCAN;
                  if (q_cmd.kind == CMD_P2L_DN) begin
                     idx_in     = count_ff - 1'b1;
                     walk_dn_in = 1'b1;
                  end else begin
                     idx_in     = '0;
                     walk_dn_in = 1'b0;
                  end
               end
            end
         end

         BK_SCAN: begin
            pend_in = (left_ff != '0);
            if (left_ff != '0) begin
               pend_idx_in = idx_ff;
               idx_in      = walk_dn_ff ? idx_ff - 1'b1 : idx_ff + 1'b1;
               left_in     = left_ff - 1'b1;
            end
            total_in = total_nx;
            if (stop || walk_end) begin
               pend_in = 1'b0;
               pos_in  = sp;
               if (cmd_ff.kind == CMD_SET) begin
                  if (stop && hit_match && size_one) begin
                     // delete: pull the tail down by one
                     state_in   = BK_SHIFT;
                     idx_in     = sp + 1'b1;
                     left_in    = count_ff - 1'b1 - sp;
                     walk_dn_in = 1'b0;
                     count_in   = count_ff - 1'b1;
                  end else if (stop && hit_match) begin
                     state_in = BK_WRITE;
                  end else if (size_one) begin
                     state_in      = BK_IDLE;
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '{value: '0, status: ST_OK};
                  end else if (count_ff == CNT_BITS'(ENTRIES)) begin
                     state_in      = BK_IDLE;
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '{value: '0, status: ST_FULL};
                  end else begin
                     // insert: push the tail up by one, top entry first
                     state_in   = BK_SHIFT;
                     idx_in     = count_ff - 1'b1;
                     left_in    = count_ff - sp;
                     walk_dn_in = 1'b1;
                     count_in   = count_ff + 1'b1;
                  end
               end else begin
                  state_in      = BK_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '{value: stop ? stop_val : end_val, status: ST_OK};
               end
            end
         end

         BK_SHIFT: begin
            pend_in = (left_ff != '0);
            if (left_ff != '0) begin
               pend_idx_in = idx_ff;
               idx_in      = walk_dn_ff ? idx_ff - 1'b1 : idx_ff + 1'b1;
               left_in     = left_ff - 1'b1;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = dst_idx[IDX_BITS-1:0];
               wr_data = rd_data_ff;
            end
            if (walk_end) begin
               if (walk_dn_ff) begin
                  state_in = BK_WRITE;
               end else begin
                  state_in      = BK_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '{value: '0, status: ST_OK};
               end
            end
         end

         BK_WRITE: begin
            wr_en         = 1'b1;
            state_in      = BK_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_in        = '{value: '0, status: ST_OK};
         end

         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      left_ff     <= left_in;
      pend_idx_ff <= pend_idx_in;
      pos_ff      <= pos_in;
      walk_dn_ff  <= walk_dn_in;
      total_ff    <= total_in;
      rsp_ff      <= rsp_in;
   end

   // Table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= tbl_mem[rd_addr];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;
   assign tbl_count  = count_ff;

endmodule

### rtl/core/expanded_grid_coordinate_map.sv
// Expanded grid coordinate map: a sorted table of up to ENTRIES logical cells
// wider than one unit, with set/get of a cell's size and mapping between
// logical and physical coordinates. Issue an item by raising start while busy
// is low; each item gives exactly one result, shown on rsp_item for a single
// cycle with rsp_strobe high, and the receiver must take it then (there is no
// back-pressure). Items enter a front stage and a two-item queue, so a few
// can be taken while the back end works; an item passes through the front
// stage's holding register and then the queue before an idle back end
// picks it up. The back end reads the table one entry per cycle through a
// single registered memory port. Get and the reverse map stop their walk
// early once the answer is found, while logical-to-physical walks every
// entry; a zero-size set is rejected without a walk, and any other set walks
// only to its insert point, after which an insert or delete moves only the
// entries above it, one per cycle. Results come back in issue order. status
// reports a full table on insert or a rejected zero size; no clearing pass
// runs after reset.
module expanded_grid_coordinate_map import egcm_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int CNT_BITS = $clog2(ENTRIES + 1);

   // front -> queue
   logic    q_push, q_full;
   cmd_type q_push_cmd;

   // queue -> back
   logic    q_pop, q_empty;
   cmd_type q_pop_cmd;

   logic [CNT_BITS-1:0] tbl_count;

   // Front: takes items and sorts them into work kinds
   egcm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_push_cmd)
   );

   // Short queue decouples intake from table work
   egcm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_cmd  (q_pop_cmd)
   );

   // Back: walks and edits the table, builds results
   egcm_back #(
      .ENTRIES  (ENTRIES),
      .CNT_BITS (CNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_cmd      (q_pop_cmd),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .tbl_count  (tbl_count)
   );

   // Coming out of reset nothing is pending and intake is open
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("busy or result strobe right after reset");

   // A full report only when the table really is full
   a_full_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == ST_FULL) |-> (tbl_count == CNT_BITS'(ENTRIES)))
      else $error("table full reported with free entries");

   // Rejected sets leave the entry count alone
   a_reject_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != ST_OK) |-> $stable(tbl_count))
      else $error("entry count changed on a rejected set");

endmodule

### dv/tb_expanded_grid_coordinate_map.sv
`timescale 1ns / 1ps

module tb_expanded_grid_coordinate_map;
   import egcm_pkg::*;

   localparam int TABLE_DEPTH  = ENTRIES_DEFAULT;
   localparam int RUN_LIMIT    = 400000;   // cycles, far above a slow clean run
   localparam int RANDOM_OPS   = 250;      // per idling phase, three phases
   localparam int SETTLE_DELAY = 2 * TABLE_DEPTH + 10;

   // Stimulus backlog entry: the item plus how the driver should pace it
   typedef struct {
      req_type item;
      bit      drain;      // hold off until no result is outstanding
      int      idle_pct;   // chance per cycle that the sender stays quiet
   } queued_op_t;

   // Expected result, stamped with the acceptance time so that a result
   // strobed at that same edge can never be matched to it
   typedef struct {
      rsp_type         rsp;
      longint unsigned taken_at;
   } awaited_t;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   queued_op_t op_backlog[$];
   awaited_t   awaited_results[$];
   int         error_count = 0;
   int         cycle_count = 0;

   // Pacing applied to items as they are queued
   int         cur_idle_pct = 23;
   bit         next_drain   = 1'b0;

   // Predictor copy of the cell table, sorted ascending by location
   logic signed [COORD_BITS-1:0] tbl_loc[TABLE_DEPTH];
   logic [SIZE_BITS-1:0]         tbl_size[TABLE_DEPTH];
   int                           tbl_count = 0;

   // Driver / monitor scratch
   rsp_type  predicted;
   awaited_t due;
   bit       offer_next;

   expanded_grid_coordinate_map #(
      .ENTRIES(TABLE_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // Applies one item to the predicted table and returns the result it gives.
   // Sums are done in 64 bits, then wrapped to the value width.
   task automatic apply_cell_op(input req_type item, output rsp_type outcome);
      longint     c;
      longint     l;
      longint     s;
      longint     total;
      longint     v;
      int         pos;
      int         k;
      bit         done;
      status_type st;
      c     = longint'($signed(item.coord));
      s     = longint'(item.cell_size);
      v     = 0;
      total = 0;
      done  = 1'b0;
      st    = ST_OK;
      case (item.op)
         OP_SET: begin
            if (item.cell_size == '0) begin
               st = ST_ZERO;
            end else begin
               pos = 0;
               while (pos < tbl_count && longint'(tbl_loc[pos]) < c) pos++;
               if (pos < tbl_count && longint'(tbl_loc[pos]) == c) begin
                  // present: resize in place, or size one removes it
                  if (s == 1) begin
                     for (k = pos; k + 1 < tbl_count; k++) begin
                        tbl_loc[k]  = tbl_loc[k+1];
                        tbl_size[k] = tbl_size[k+1];
                     end
                     tbl_count--;
                  end else begin
                     tbl_size[pos] = item.cell_size;
                  end
               end else if (s != 1) begin
                  if (tbl_count >= TABLE_DEPTH) begin
                     st = ST_FULL;
                  end else begin
                     for (k = tbl_count; k > pos; k--) begin
                        tbl_loc[k]  = tbl_loc[k-1];
                        tbl_size[k] = tbl_size[k-1];
                     end
                     tbl_loc[pos]  = item.coord;
                     tbl_size[pos] = item.cell_size;
                     tbl_count++;
                  end
               end
            end
         end
         OP_GET: begin
            v = 1;
            for (k = 0; k < tbl_count && !done; k++) begin
               if (longint'(tbl_loc[k]) == c) begin
                  v    = longint'(tbl_size[k]);
                  done = 1'b1;
               end
            end
         end
         OP_L2P: begin
            for (k = 0; k < tbl_count; k++) begin
               l = longint'(tbl_loc[k]);
               s = longint'(tbl_size[k]);
               if (l >= 0 && l < c) total += s - 1;
               if (l < 0 && l >= c) total -= s - 1;
            end
            v = c + total;
         end
         default: begin
            // reverse map: positive side walks up, negative side walks down
            if (c >= 0) begin
               for (k = 0; k < tbl_count && !done; k++) begin
                  l = longint'(tbl_loc[k]);
                  s = longint'(tbl_size[k]);
                  if (l >= 0) begin
                     if (total + l > c) begin
                        v    = c - total;
                        done = 1'b1;
                     end else if (total + l + (s - 1) >= c) begin
                        v    = l;
                        done = 1'b1;
                     end else begin
                        total += s - 1;
                     end
                  end
               end
            end else begin
               for (k = tbl_count - 1; k >= 0 && !done; k--) begin
                  l = longint'(tbl_loc[k]);
                  s = longint'(tbl_size[k]);
                  if (l < 0) begin
                     if (total + l < c) begin
                        v    = c - total;
                        done = 1'b1;
                     end else if (total + l - (s - 1) <= c) begin
                        v    = l;
                        done = 1'b1;
                     end else begin
                        total -= s - 1;
                     end
                  end
               end
            end
            if (!done) v = c - total;
         end
      endcase
      outcome.value  = v[VALUE_BITS-1:0];
      outcome.status = st;
   endtask

   task automatic push_op(input op_type op, input int coord, input int size);
      queued_op_t q;
      q.item.op        = op;
      q.item.coord     = COORD_BITS'(coord);
      q.item.cell_size = SIZE_BITS'(size);
      q.drain          = next_drain;
      q.idle_pct       = cur_idle_pct;
      next_drain       = 1'b0;
      op_backlog.push_back(q);
   endtask

   // Mostly a small pool of locations so that sets hit, resize and delete
   // existing cells and the table fills up; the rest spread wider.
   function automatic int pick_location();
      int roll;
      roll = $urandom_range(99);
      if (roll < 65) return (int'($urandom_range(23)) - 12) * 7;
      if (roll < 85) return int'($urandom_range(400)) - 200;
      return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic int pick_physical();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return int'($urandom_range(600)) - 300;
      if (roll < 75) return pick_location();
      if (roll < 88) return int'($urandom_range(40000)) - 20000;
      return int'($urandom_range(65535)) - 32768;
   endfunction

   // shrink biases sets toward size one so the table drains again
   task automatic push_random_op(input bit shrink);
      int roll;
      int size;
      roll = $urandom_range(99);
      if (roll < 35) begin
         roll = $urandom_range(99);
         if (roll < 8)                    size = 0;
         else if (roll < (shrink ? 60 : 20)) size = 1;
         else if (roll < 88)              size = $urandom_range(16, 2);
         else                             size = $urandom_range(4095);
         push_op(OP_SET, pick_location(), size);
      end else if (roll < 52) begin
         push_op(OP_GET, pick_location(), $urandom_range(4095));
      end else if (roll < 72) begin
         push_op(OP_L2P, pick_location(), $urandom_range(4095));
      end else begin
         push_op(OP_P2L, pick_physical(), $urandom_range(4095));
      end
   endtask

   // Driver: holds an item until start && !busy takes it, then predicts its
   // result and decides, once per edge, whether to offer the next one.
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_item <= '0;
      end else begin
         offer_next = !start;
         if (start && !busy) begin
            apply_cell_op(op_backlog[0].item, predicted);
            awaited_results.push_back('{rsp: predicted, taken_at: $time});
            void'(op_backlog.pop_front());
            offer_next = 1'b1;
         end
         if (offer_next) begin
            if (op_backlog.size() != 0
                && !(op_backlog[0].drain && awaited_results.size() != 0)
                && $urandom_range(99) >= op_backlog[0].idle_pct) begin
               start    <= 1'b1;
               req_item <= op_backlog[0].item;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result is taken at this edge and checked against
   // the oldest item accepted at an earlier edge.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (awaited_results.size() == 0 || awaited_results[0].taken_at >= $time) begin
            report_mismatch($sformatf("result with no item outstanding value=%0d status=%0d",
                                      rsp_item.value, rsp_item.status));
         end else begin
            due = awaited_results.pop_front();
            if (rsp_item.value !== due.rsp.value)
               report_mismatch($sformatf("value got %0d want %0d",
                                         rsp_item.value, due.rsp.value));
            if (rsp_item.status !== due.rsp.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_item.status, due.rsp.status));
         end
      end
   end

   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      // Directed: empty table, zero size, size one on an absent cell,
      // extreme locations and sizes, resize in place, maps on both sides of
      // zero and at the coordinate extremes, then deletes.
      cur_idle_pct = 23;
      push_op(OP_GET, 0, 0);
      push_op(OP_L2P, -32768, 4095);
      push_op(OP_P2L, 32767, 0);
      push_op(OP_SET, 5, 0);
      push_op(OP_SET, 7, 1);
      push_op(OP_SET, 32767, 4095);
      push_op(OP_SET, -32768, 4095);
      push_op(OP_SET, 0, 3);
      push_op(OP_SET, -1, 2);
      push_op(OP_GET, 32767, 0);
      push_op(OP_SET, 0, 4095);
      push_op(OP_SET, 0, 5);
      push_op(OP_L2P, 32767, 0);
      push_op(OP_L2P, -32768, 0);
      push_op(OP_L2P, 1, 0);
      push_op(OP_L2P, -1, 0);
      push_op(OP_P2L, 2, 0);
      push_op(OP_P2L, 5, 0);
      push_op(OP_P2L, -2, 0);
      push_op(OP_P2L, -32768, 0);
      push_op(OP_P2L, 32767, 0);
      push_op(OP_SET, 0, 1);
      push_op(OP_GET, 0, 0);
      push_op(OP_SET, -32768, 1);
      push_op(OP_GET, -7, 0);

      // Random: sender idles 23%, then 65%, then never. Each phase opens
      // with a full drain; grow and shrink stretches alternate so the table
      // runs between sparse and full (full-table rejects included).
      for (int phase = 0; phase < 3; phase++) begin
         cur_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 65 : 0;
         next_drain   = 1'b1;
         for (int n = 0; n < RANDOM_OPS; n++) begin
            push_random_op(((n / 50) % 2) == 1);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (op_backlog.size() != 0 || awaited_results.size() != 0) @(posedge clock);
      // catch any stray result after the last one expected
      repeat (SETTLE_DELAY) @(posedge clock);

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
